// File: design/ihtp_pkg.sv
package ihtp_pkg;

    localparam int unsigned CLS_W = 3;
    localparam int unsigned CLASS_COUNT = 5;

    localparam logic [CLS_W-1:0] CLS_ICMP  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_IGMP  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_TCP   = 3'd2;
    localparam logic [CLS_W-1:0] CLS_UDP   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_OTHER = 3'd4;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [15:0] ETH_BYTES = 16'd14;
    localparam logic [15:0] POS_IHL   = 16'd14;
    localparam logic [15:0] POS_PROTO = 16'd23;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;
    localparam logic [15:0] TCP_CAPTURE_BYTES = 16'd14;

    localparam logic [31:0] MATCH_ADDRESS_RESET = 32'd2130706433;

    localparam logic CFG_MATCH_ADDRESS = 1'b0;
    localparam logic CFG_MATCH_ENABLE  = 1'b1;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        last_byte;
        logic [15:0] wire_length;
    } t_in_item;

    typedef struct packed {
        logic [CLS_W-1:0] protocol_class;
        logic [31:0]      class_count;
        logic [31:0]      total_count;
        logic [15:0]      tcp_src_port;
        logic [15:0]      tcp_dst_port;
        logic [31:0]      relative_sequence;
        logic [31:0]      relative_acknowledge;
        logic [15:0]      payload_length;
        logic             flag_push;
        logic             flag_acknowledge;
        logic             flag_synchronize;
        logic             flag_finish;
    } t_out_item;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [31:0]      seq;
        logic [31:0]      ack;
        logic [7:0]       flags;
        logic [7:0]       hdr_bytes;
        logic [15:0]      wire_length;
    } t_frame_rec;

    function automatic logic [CLS_W-1:0] class_of(input logic [7:0] proto);
        unique case (proto)
            PROTO_ICMP: return CLS_ICMP;
            PROTO_IGMP: return CLS_IGMP;
            PROTO_TCP:  return CLS_TCP;
            PROTO_UDP:  return CLS_UDP;
            default:    return CLS_OTHER;
        endcase
    endfunction

endpackage

// File: design/ihtp_front.sv
module ihtp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  ihtp_pkg::t_in_item   i_in_item,
    input  logic                 i_q_full,
    input  logic [31:0]          i_match_address,
    input  logic                 i_match_enable,
    output logic                 o_in_stall,
    output logic                 o_push,
    output ihtp_pkg::t_frame_rec o_rec
);
    import ihtp_pkg::*;

    logic [15:0] r_pos;
    logic [5:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [31:0] r_saddr;
    logic [31:0] r_daddr;
    logic [15:0] r_sport;
    logic [15:0] r_dport;
    logic [31:0] r_seq;
    logic [31:0] r_ack;
    logic [7:0]  r_off;
    logic [7:0]  r_flags;

    logic [5:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [31:0] n_saddr;
    logic [31:0] n_daddr;
    logic [15:0] n_sport;
    logic [15:0] n_dport;
    logic [31:0] n_seq;
    logic [31:0] n_ack;
    logic [7:0]  n_off;
    logic [7:0]  n_flags;

    logic [7:0]  b;
    logic [15:0] tcp_base;
    logic [15:0] tcp_off;
    logic        in_tcp;
    logic        accepted;
    logic        frame_match;

    assign b          = i_in_item.frame_byte;
    assign o_in_stall = i_q_full;
    assign accepted   = i_in_valid && !i_q_full;

    always_comb begin
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_saddr = r_saddr;
        n_daddr = r_daddr;
        n_sport = r_sport;
        n_dport = r_dport;
        n_seq   = r_seq;
        n_ack   = r_ack;
        n_off   = r_off;
        n_flags = r_flags;
        if (r_pos == POS_IHL) begin
            n_ihl = {b[3:0], 2'b00};
        end
        if (r_pos == POS_PROTO) begin
            n_proto = b;
        end
        case (r_pos)
            16'd26: n_saddr[31:24] = b;
            16'd27: n_saddr[23:16] = b;
            16'd28: n_saddr[15:8]  = b;
            16'd29: n_saddr[7:0]   = b;
            16'd30: n_daddr[31:24] = b;
            16'd31: n_daddr[23:16] = b;
            16'd32: n_daddr[15:8]  = b;
            16'd33: n_daddr[7:0]   = b;
            default: ;
        endcase
        tcp_base = ETH_BYTES + {10'd0, n_ihl};
        tcp_off  = r_pos - tcp_base;
        in_tcp   = (r_pos >= tcp_base) && (tcp_off < TCP_CAPTURE_BYTES);
        if (in_tcp) begin
            case (tcp_off[3:0])
                4'd0:  n_sport[15:8] = b;
                4'd1:  n_sport[7:0]  = b;
                4'd2:  n_dport[15:8] = b;
                4'd3:  n_dport[7:0]  = b;
                4'd4:  n_seq[31:24]  = b;
                4'd5:  n_seq[23:16]  = b;
                4'd6:  n_seq[15:8]   = b;
                4'd7:  n_seq[7:0]    = b;
                4'd8:  n_ack[31:24]  = b;
                4'd9:  n_ack[23:16]  = b;
                4'd10: n_ack[15:8]   = b;
                4'd11: n_ack[7:0]    = b;
                4'd12: n_off         = b;
                4'd13: n_flags       = b;
                default: ;
            endcase
        end
    end

    assign frame_match = !i_match_enable || (n_saddr == i_match_address) ||
                         (n_daddr == i_match_address);

    assign o_push = accepted && i_in_item.last_byte && frame_match;

    always_comb begin
        o_rec.cls         = class_of(n_proto);
        o_rec.sport       = n_sport;
        o_rec.dport       = n_dport;
        o_rec.seq         = n_seq;
        o_rec.ack         = n_ack;
        o_rec.flags       = n_flags;
        o_rec.hdr_bytes   = tcp_base[7:0] + {2'b00, n_off[7:4], 2'b00};
        o_rec.wire_length = i_in_item.wire_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accepted && i_in_item.last_byte)) begin
            r_pos   <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_saddr <= '0;
            r_daddr <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_seq   <= '0;
            r_ack   <= '0;
            r_off   <= '0;
            r_flags <= '0;
        end else if (accepted) begin
            if (r_pos != POS_MAX) begin
                r_pos <= r_pos + 16'd1;
            end
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_saddr <= n_saddr;
            r_daddr <= n_daddr;
            r_sport <= n_sport;
            r_dport <= n_dport;
            r_seq   <= n_seq;
            r_ack   <= n_ack;
            r_off   <= n_off;
            r_flags <= n_flags;
        end
    end

endmodule

// File: design/ihtp_queue.sv
module ihtp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ihtp_pkg::t_frame_rec i_rec,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output ihtp_pkg::t_frame_rec o_rec
);
    import ihtp_pkg::*;

    t_frame_rec r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: design/ihtp_back.sv
module ihtp_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  ihtp_pkg::t_frame_rec i_rec,
    input  logic                 i_out_stall,
    output logic                 o_pop,
    output logic                 o_out_valid,
    output ihtp_pkg::t_out_item  o_out_item
);
    import ihtp_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt [CLASS_COUNT];
    logic [COUNT_WIDTH-1:0] r_total;
    logic [31:0]            r_base;
    logic                   r_base_valid;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [COUNT_WIDTH-1:0] n_cls_cnt;
    logic [COUNT_WIDTH-1:0] n_total;
    logic [31:0]            eff_base;
    logic                   is_tcp;
    t_out_item              n_out;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign is_tcp    = (i_rec.cls == CLS_TCP);
    assign n_cls_cnt = r_cnt[i_rec.cls] + COUNT_WIDTH'(1);
    assign n_total   = r_total + COUNT_WIDTH'(1);
    assign eff_base  = r_base_valid ? r_base : i_rec.seq;

    always_comb begin
        n_out = '0;
        n_out.protocol_class = i_rec.cls;
        n_out.class_count    = 32'(n_cls_cnt);
        n_out.total_count    = 32'(n_total);
        if (is_tcp) begin
            n_out.tcp_src_port         = i_rec.sport;
            n_out.tcp_dst_port         = i_rec.dport;
            n_out.relative_sequence    = i_rec.seq - eff_base;
            n_out.relative_acknowledge = i_rec.ack - eff_base;
            if (i_rec.wire_length > {8'd0, i_rec.hdr_bytes}) begin
                n_out.payload_length = i_rec.wire_length - {8'd0, i_rec.hdr_bytes};
            end
            n_out.flag_push        = i_rec.flags[3];
            n_out.flag_acknowledge = i_rec.flags[4];
            n_out.flag_synchronize = i_rec.flags[1];
            n_out.flag_finish      = i_rec.flags[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_total      <= '0;
            r_base       <= '0;
            r_base_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cnt[i_rec.cls] <= n_cls_cnt;
                r_total          <= n_total;
                if (is_tcp && !r_base_valid) begin
                    r_base       <= i_rec.seq;
                    r_base_valid <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/ipv4_tcp_header_parse_count.sv
// Counts Ethernet/IPv4 frames by protocol class and reports TCP header fields.
// The input channel takes one frame byte per item, with last_byte set on the
// final byte and wire_length valid on it; the block accepts one byte every
// cycle unless the queue is full. Bytes only update front-end header registers.
// On the last byte the frame is checked against the address filter, and a
// frame that passes leaves a record in a two-entry queue; a rejected frame
// leaves nothing. The back end turns each record into one result item: it
// updates the class and total counters and the TCP base sequence, and loads
// the output register. The result passes through the queue and the output
// register, and the back end delivers one result per cycle while the receiver
// does not stall.
// When the receiver stalls, the output register holds its item and the queue
// fills; input is stalled only while both queue entries are occupied.
// Configuration writes on the plain write port take effect at the next edge;
// the user must write only while the block is idle; it does not check this.
// Synchronous reset empties the queue and output register, clears all counters
// and the base sequence, and restores the filter to 127.0.0.1, enabled.
module ipv4_tcp_header_parse_count #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ihtp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ihtp_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import ihtp_pkg::*;

    logic [31:0] r_match_address;
    logic        r_match_enable;

    logic        w_push;
    logic        w_pop;
    logic        w_q_valid;
    logic        w_q_full;
    t_frame_rec  w_push_rec;
    t_frame_rec  w_q_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_address <= MATCH_ADDRESS_RESET;
            r_match_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MATCH_ADDRESS: r_match_address <= i_cfg_data;
                CFG_MATCH_ENABLE:  r_match_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ihtp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_item       (i_in_item),
        .i_q_full        (w_q_full),
        .i_match_address (r_match_address),
        .i_match_enable  (r_match_enable),
        .o_in_stall      (o_in_stall),
        .o_push          (w_push),
        .o_rec           (w_push_rec)
    );

    ihtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_rec   (w_q_rec)
    );

    ihtp_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_rec       (w_q_rec),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("frame record pushed into a full queue");

    a_non_tcp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.protocol_class != CLS_TCP) |->
        (o_out_item.tcp_src_port == 16'd0 && o_out_item.payload_length == 16'd0 &&
         o_out_item.relative_sequence == 32'd0))
        else $error("non-TCP result carries TCP fields");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("back end took from an empty queue");
`endif

endmodule
